FILE: src/tbeq_pkg.sv
package tbeq_pkg;

    // configuration port
    localparam int NUM_REGS = 8;
    localparam int CFG_AW   = 3;
    localparam int CFG_W    = 64;

    // coefficients: signed q4.28, two to a register
    localparam int COEF_W     = 32;
    localparam int COEF_FRAC  = 28;
    localparam int COEF_IDX_W = 4;

    // sections and the coefficient slot of each term within a section
    localparam int NUM_SECT = 3;
    localparam int SEC_W    = 2;

    localparam logic [COEF_IDX_W-1:0] CK_B0    = 4'd0;
    localparam logic [COEF_IDX_W-1:0] CK_B1    = 4'd1;
    localparam logic [COEF_IDX_W-1:0] CK_B2    = 4'd2;
    localparam logic [COEF_IDX_W-1:0] CK_A1    = 4'd3;
    localparam logic [COEF_IDX_W-1:0] CK_A2    = 4'd4;
    localparam logic [COEF_IDX_W-1:0] GAIN_IDX = 4'd15;

    // b0 of every section and the makeup gain start at 1.0
    localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
        64'h0000_0000_1000_0000,
        64'h0000_0000_0000_0000,
        64'h1000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_1000_0000,
        64'h0000_0000_0000_0000,
        64'h1000_0000_0000_0000
    };

    typedef enum logic {
        OPND_X,
        OPND_Y
    } t_opnd;

    typedef enum logic [2:0] {
        ADD_NONE,
        ADD_Y,
        ADD_ACC,
        ADD_Z1,
        ADD_Z2
    } t_add_op;

    typedef struct packed {
        logic                  load_in;
        logic                  adv;
        logic [COEF_IDX_W-1:0] coef_idx;
        logic                  coef_neg;
        t_opnd                 opnd;
        t_add_op               add_op;
        logic [SEC_W-1:0]      add_sec;
        logic                  capture;
    } t_dp_cmd;

endpackage

FILE: src/three_biquad_cascade_eq_core.sv
// channel  | dir | beat contents
// ---------+-----+---------------------------------------------------------
// s_axis   | in  | tdata: sample_in (signed); tlast: last_in
// m_axis   | out | tdata: sample_out (signed, zero padded); tuser: clipped;
//          |     | tlast: last_out
// cfg      | in  | 8 x 64-bit coefficient registers, write only
//
// the block works on one item at a time: it takes no new input beat until the
// result of the last one is in the output register; its schedule is set by the
// single shared multiply unit, six issue slots per section plus three for gain
// a result waiting on m_axis does not block the next input beat; that item
// then holds at its last step until the output register frees
// synchronous active-low reset clears the section delays and loads pass-through
// coefficients (unity b0 and gain)
module three_biquad_cascade_eq_core #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int STATE_WIDTH  = 48
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // input sample channel
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,  // [SAMPLE_WIDTH-1:0] sample_in
    input  logic                                s_axis_tlast,

    // result channel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_axis_tdata,  // [SAMPLE_WIDTH-1:0] sample_out
    output logic                                m_axis_tuser,  // [0] clipped
    output logic                                m_axis_tlast,

    // coefficient write port
    input  logic                                i_cfg_wr_en,
    input  logic [tbeq_pkg::CFG_AW-1:0]         i_cfg_addr,
    input  logic [tbeq_pkg::CFG_W-1:0]          i_cfg_wdata
);
    import tbeq_pkg::*;

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    t_dp_cmd                         w_cmd;
    logic signed [SAMPLE_WIDTH-1:0]  w_out_sample;
    logic                            w_out_clip;
    logic                            w_out_last;

    // sequencer: issues one mac slot and at most one saturating add per cycle unless stalled
    tbeq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    // coefficients, section delays, shared mac and format conversion
    tbeq_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .STATE_WIDTH  (STATE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg_we    (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    ($signed(s_axis_tdata[SAMPLE_WIDTH-1:0])),
        .i_last      (s_axis_tlast),
        .o_sample    (w_out_sample),
        .o_clip      (w_out_clip),
        .o_last      (w_out_last)
    );

    // padding bits above the sample stay zero
    assign m_axis_tdata = TDATA_W'($unsigned(w_out_sample));
    assign m_axis_tuser = w_out_clip;
    assign m_axis_tlast = w_out_last;

endmodule

FILE: src/tbeq_mac.sv
module tbeq_mac #(
    parameter int STATE_WIDTH = 48
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [tbeq_pkg::COEF_W:0]      i_coef,
    input  logic signed [STATE_WIDTH-1:0]         i_opnd,
    output logic signed [STATE_WIDTH-1:0]         o_prod
);
    import tbeq_pkg::*;

    localparam int PW = STATE_WIDTH + 34;
    localparam int OW = 2 * COEF_W + 1;
    localparam logic signed [PW-1:0] RND_POS = PW'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [PW-1:0] RND_NEG = RND_POS - PW'(1);
    localparam logic signed [STATE_WIDTH-1:0] SMAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
    localparam logic signed [STATE_WIDTH-1:0] SMIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};

    logic signed [OW-1:0]        w_vx;
    logic signed [COEF_W:0]      w_vl;
    logic signed [COEF_W:0]      w_vh;
    logic signed [2*COEF_W+1:0]  r_p0;
    logic signed [2*COEF_W+1:0]  r_p1;
    logic                        r_neg;
    logic signed [PW-1:0]        w_sum;
    logic signed [PW-1:0]        w_shift;
    logic signed [STATE_WIDTH-1:0] w_sat;
    logic signed [STATE_WIDTH-1:0] r_prod;

    // operand split into an unsigned low word and a signed high word
    assign w_vx = OW'(i_opnd);
    assign w_vl = $signed({1'b0, w_vx[COEF_W-1:0]});
    assign w_vh = $signed(w_vx[OW-1:COEF_W]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0  <= i_coef * w_vl;
            r_p1  <= i_coef * w_vh;
            r_neg <= (i_coef != '0) && (i_opnd != '0)
                     && (i_coef[COEF_W] ^ i_opnd[STATE_WIDTH-1]);
        end
    end

    // recombine, round half away from zero, saturate
    always_comb begin
        w_sum   = (PW'(r_p1) <<< COEF_W) + PW'(r_p0) + (r_neg ? RND_NEG : RND_POS);
        w_shift = w_sum >>> COEF_FRAC;
        if ((&w_shift[PW-1:STATE_WIDTH-1]) || !(|w_shift[PW-1:STATE_WIDTH-1])) begin
            w_sat = w_shift[STATE_WIDTH-1:0];
        end else begin
            w_sat = w_shift[PW-1] ? SMIN : SMAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_sat;
        end
    end

    assign o_prod = r_prod;

endmodule

FILE: src/tbeq_dp.sv
module tbeq_dp #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int STATE_WIDTH  = 48
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tbeq_pkg::t_dp_cmd                    i_cmd,
    input  logic                                 i_cfg_we,
    input  logic [tbeq_pkg::CFG_AW-1:0]          i_cfg_addr,
    input  logic [tbeq_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_sample,
    input  logic                                 i_last,
    output logic signed [SAMPLE_WIDTH-1:0]       o_sample,
    output logic                                 o_clip,
    output logic                                 o_last
);
    import tbeq_pkg::*;

    localparam int SW  = STATE_WIDTH;
    localparam int SW1 = STATE_WIDTH + 1;
    // format shift between sample and internal fraction bits
    localparam int D   = STATE_WIDTH - SAMPLE_WIDTH - 8;
    localparam int DL  = (D > 0) ? D : 0;
    localparam int DR  = (D < 0) ? -D : 0;
    localparam int DLH = (D > 0) ? D - 1 : 0;
    localparam int DRH = (D < 0) ? -D - 1 : 0;
    localparam int CW  = STATE_WIDTH + 1;
    localparam int QW  = STATE_WIDTH + 1 + DR;
    localparam logic signed [CW-1:0] IN_HALF  = (DR > 0) ? (CW'(1) <<< DRH) : '0;
    localparam logic signed [QW-1:0] OUT_HALF = (D > 0) ? (QW'(1) <<< DLH) : '0;
    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] OMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] OMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    function automatic logic signed [SW-1:0] sadd(input logic signed [SW-1:0] a,
                                                  input logic signed [SW-1:0] b);
        logic signed [SW1-1:0] s;
        s = SW1'(a) + SW1'(b);
        if (s[SW] != s[SW-1]) begin
            return s[SW] ? SMIN : SMAX;
        end
        return s[SW-1:0];
    endfunction

    logic [CFG_W-1:0]          r_cfg [NUM_REGS];
    logic signed [SW-1:0]      r_z1 [NUM_SECT];
    logic signed [SW-1:0]      r_z2 [NUM_SECT];
    logic signed [SW-1:0]      r_x;
    logic signed [SW-1:0]      r_y;
    logic signed [SW-1:0]      r_acc;
    logic signed [SW-1:0]      r_prev;
    logic                      r_last;
    logic signed [SAMPLE_WIDTH-1:0] r_out_sample;
    logic                      r_out_clip;
    logic                      r_out_last;

    logic [CFG_W-1:0]          w_reg;
    logic signed [COEF_W-1:0]  w_half;
    logic signed [COEF_W:0]    w_coef;
    logic signed [SW-1:0]      w_opnd;
    logic signed [SW-1:0]      w_prod;
    logic signed [SW-1:0]      w_add_a;
    logic signed [SW-1:0]      w_add_b;
    logic signed [SW-1:0]      w_sum;
    logic signed [CW-1:0]      w_in_q;
    logic signed [QW-1:0]      w_out_q;
    logic                      w_out_ok;

    // coefficient fetch: half 5*section+term, optionally negated for the a-terms
    assign w_reg  = r_cfg[i_cmd.coef_idx[COEF_IDX_W-1:1]];
    assign w_half = $signed(i_cmd.coef_idx[0] ? w_reg[2*COEF_W-1:COEF_W] : w_reg[COEF_W-1:0]);
    assign w_coef = i_cmd.coef_neg ? -((COEF_W+1)'(w_half)) : (COEF_W+1)'(w_half);
    assign w_opnd = (i_cmd.opnd == OPND_Y) ? r_y : r_x;

    tbeq_mac #(
        .STATE_WIDTH (STATE_WIDTH)
    ) u_mac (
        .i_clk  (i_clk),
        .i_en   (i_cmd.adv),
        .i_coef (w_coef),
        .i_opnd (w_opnd),
        .o_prod (w_prod)
    );

    always_comb begin
        w_add_a = w_prod;
        w_add_b = r_prev;
        case (i_cmd.add_op)
            ADD_Y:   w_add_b = r_z1[i_cmd.add_sec];
            ADD_Z1: begin
                w_add_a = r_acc;
                w_add_b = r_z2[i_cmd.add_sec];
            end
            default: w_add_b = r_prev;
        endcase
        w_sum = sadd(w_add_a, w_add_b);
    end

    // sample to internal format, round half up when narrowing
    assign w_in_q = ((CW'(i_sample) + IN_HALF) >>> DR) <<< DL;

    // internal to sample format, then clamp
    assign w_out_q  = ((QW'(w_prod) + OUT_HALF) >>> DL) <<< DR;
    assign w_out_ok = (&w_out_q[QW-1:SAMPLE_WIDTH-1]) || !(|w_out_q[QW-1:SAMPLE_WIDTH-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
            for (int i = 0; i < NUM_SECT; i++) begin
                r_z1[i] <= '0;
                r_z2[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cfg[i_cfg_addr] <= i_cfg_wdata;
            end
            case (i_cmd.add_op)
                ADD_Z1:  r_z1[i_cmd.add_sec] <= w_sum;
                ADD_Z2:  r_z2[i_cmd.add_sec] <= w_sum;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.adv) begin
            r_prev <= w_prod;
        end
        if (i_cmd.load_in) begin
            r_x    <= w_in_q[SW-1:0];
            r_last <= i_last;
        end else if (i_cmd.add_op == ADD_ACC) begin
            // section output becomes the next section's input
            r_x <= r_y;
        end
        if (i_cmd.add_op == ADD_Y) begin
            r_y <= w_sum;
        end
        if (i_cmd.add_op == ADD_ACC) begin
            r_acc <= w_sum;
        end
        if (i_cmd.capture) begin
            r_out_sample <= w_out_ok ? w_out_q[SAMPLE_WIDTH-1:0]
                                     : (w_out_q[QW-1] ? OMIN : OMAX);
            r_out_clip   <= !w_out_ok;
            r_out_last   <= r_last;
        end
    end

    assign o_sample = r_out_sample;
    assign o_clip   = r_out_clip;
    assign o_last   = r_out_last;

endmodule

FILE: src/tbeq_ctrl.sv
module tbeq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output tbeq_pkg::t_dp_cmd o_cmd
);
    import tbeq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // six issue slots per section; the tail reuses the first three
    typedef enum logic [2:0] {
        PH_B0,
        PH_GAP,
        PH_B1,
        PH_A1,
        PH_B2,
        PH_A2
    } t_phase;

    t_state               r_state;
    t_phase               r_phase;
    t_phase               n_phase;
    logic [SEC_W-1:0]     r_sec;
    logic                 r_out_valid;
    logic                 w_out_free;
    logic                 w_tail;
    logic [COEF_IDX_W-1:0] w_base;
    logic [SEC_W-1:0]     w_prev_sec;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_tail     = (r_sec == SEC_W'(NUM_SECT));
    assign w_base     = {r_sec, 2'b00} + COEF_IDX_W'(r_sec);
    assign w_prev_sec = r_sec - 1'b1;

    always_comb begin
        unique case (r_phase)
            PH_B0:   n_phase = PH_GAP;
            PH_GAP:  n_phase = PH_B1;
            PH_B1:   n_phase = PH_A1;
            PH_A1:   n_phase = PH_B2;
            PH_B2:   n_phase = PH_A2;
            default: n_phase = PH_B0;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: o_cmd.load_in = i_in_valid;
            ST_RUN: begin
                o_cmd.adv = 1'b1;
                if (!w_tail) begin
                    unique case (r_phase)
                        PH_B0: begin
                            o_cmd.coef_idx = w_base + CK_B0;
                            o_cmd.opnd     = OPND_X;
                            if (r_sec != '0) begin
                                o_cmd.add_op  = ADD_Z1;
                                o_cmd.add_sec = w_prev_sec;
                            end
                        end
                        PH_GAP: begin
                            if (r_sec != '0) begin
                                o_cmd.add_op  = ADD_Z2;
                                o_cmd.add_sec = w_prev_sec;
                            end
                        end
                        PH_B1: begin
                            o_cmd.coef_idx = w_base + CK_B1;
                            o_cmd.opnd     = OPND_X;
                            o_cmd.add_op   = ADD_Y;
                            o_cmd.add_sec  = r_sec;
                        end
                        PH_A1: begin
                            o_cmd.coef_idx = w_base + CK_A1;
                            o_cmd.coef_neg = 1'b1;
                            o_cmd.opnd     = OPND_Y;
                        end
                        PH_B2: begin
                            o_cmd.coef_idx = w_base + CK_B2;
                            o_cmd.opnd     = OPND_X;
                        end
                        PH_A2: begin
                            o_cmd.coef_idx = w_base + CK_A2;
                            o_cmd.coef_neg = 1'b1;
                            o_cmd.opnd     = OPND_Y;
                            o_cmd.add_op   = ADD_ACC;
                        end
                        default: ;
                    endcase
                end else begin
                    unique case (r_phase)
                        PH_B0: begin
                            o_cmd.coef_idx = GAIN_IDX;
                            o_cmd.opnd     = OPND_Y;
                            o_cmd.add_op   = ADD_Z1;
                            o_cmd.add_sec  = w_prev_sec;
                        end
                        PH_GAP: begin
                            o_cmd.add_op  = ADD_Z2;
                            o_cmd.add_sec = w_prev_sec;
                        end
                        PH_B1: begin
                            // gained product sits in the mac until the output frees
                            o_cmd.adv     = 1'b0;
                            o_cmd.capture = w_out_free;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_B0;
            r_sec       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.capture) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_RUN;
                        r_phase <= PH_B0;
                        r_sec   <= '0;
                    end
                end
                ST_RUN: begin
                    if (w_tail && (r_phase == PH_B1)) begin
                        if (w_out_free) begin
                            r_state <= ST_IDLE;
                        end
                    end else begin
                        r_phase <= n_phase;
                        if (r_phase == PH_A2) begin
                            r_sec <= r_sec + 1'b1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: src/tbeq_checker.sv
module tbeq_checker #(
    parameter int SAMPLE_WIDTH = 24
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
    input logic                                m_axis_tuser,
    input logic                                m_axis_tlast
);

    logic       w_in_beat;
    logic       w_out_beat;
    logic [1:0] r_pend;

    assign w_in_beat  = s_axis_tvalid && s_axis_tready;
    assign w_out_beat = m_axis_tvalid && m_axis_tready;

    // items taken in but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (w_in_beat && !w_out_beat) begin
            r_pend <= r_pend + 1'b1;
        end else if (!w_in_beat && w_out_beat) begin
            r_pend <= r_pend - 1'b1;
        end
    end

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("outputs not idle after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result beat changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> !s_axis_tready)
        else $error("input taken again before the item was worked");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_beat |-> (r_pend != 2'd0))
        else $error("result beat without a pending item");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == 2'd2) |-> !s_axis_tready)
        else $error("third item accepted while two are in flight");

endmodule

bind three_biquad_cascade_eq_core tbeq_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_tbeq_checker (.*);

FILE: tb/tb_three_biquad_cascade_eq_core.sv
`timescale 1ns / 1ps

module tb_three_biquad_cascade_eq_core;
    import tbeq_pkg::*;

    localparam int SAMPLE_W = 24;
    localparam int STATE_W  = 48;
    localparam int DATA_W   = ((SAMPLE_W + 7) / 8) * 8;
    // internal words carry STATE_W-9 fraction bits, samples SAMPLE_W-1
    localparam int ALIGN    = (STATE_W - 9) - (SAMPLE_W - 1);
    localparam int SAMPLE_MAX = 2 ** (SAMPLE_W - 1) - 1;
    localparam int SAMPLE_MIN = -(2 ** (SAMPLE_W - 1));
    localparam logic [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    // coefficient halves are numbered section by section, five terms each
    localparam int TERMS_PER_SECT = CK_A2 + 1;
    localparam int RANDOM_PHASES   = 9;
    localparam int BEATS_PER_PHASE = 144;

    typedef logic signed [STATE_W-1:0] t_state;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                clipped;
        logic                last;
    } t_eq_result;

    // equalizer predictor plus the queue of results still owed by the block
    class t_eq_scoreboard;
        logic [CFG_W-1:0] coef_regs [NUM_REGS];
        t_state           delays [2*NUM_SECT];
        t_eq_result       expected_q [$];
        int               fail_count;

        function new();
            foreach (coef_regs[i]) coef_regs[i] = CFG_RESET[i];
            foreach (delays[i]) delays[i] = '0;
            fail_count = 0;
        endfunction

        function void write_reg(int idx, logic [CFG_W-1:0] value);
            if (idx < NUM_REGS) coef_regs[idx] = value;
        endfunction

        // signed q4.28 term of a section, one bit wider so that it can be negated
        function logic signed [COEF_W:0] coef(int sec, logic [COEF_IDX_W-1:0] term);
            int                flat;
            logic [COEF_W-1:0] half;
            flat = (term == GAIN_IDX) ? GAIN_IDX : TERMS_PER_SECT * sec + term;
            half = coef_regs[flat / 2][(flat % 2) * COEF_W +: COEF_W];
            return (COEF_W+1)'($signed(half));
        endfunction

        function t_state sat_add(t_state a, t_state b);
            logic signed [STATE_W:0] s;
            s = (STATE_W+1)'(a) + (STATE_W+1)'(b);
            if (s[STATE_W] != s[STATE_W-1])
                return s[STATE_W] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
            return s[STATE_W-1:0];
        endfunction

        // exact product, rounded half away from zero, saturated to the state width
        function t_state coef_mul(logic signed [COEF_W:0] c, t_state v);
            logic signed [95:0] p;
            logic [95:0]        mag;
            logic [95:0]        r;
            p = c * v;
            mag = (p < 0) ? -p : p;
            r = (mag + (96'd1 << (COEF_FRAC - 1))) >> COEF_FRAC;
            if (p < 0) begin
                if (r > (96'd1 << (STATE_W - 1))) r = 96'd1 << (STATE_W - 1);
                return -r[STATE_W-1:0];
            end
            if (r >= (96'd1 << (STATE_W - 1))) r = (96'd1 << (STATE_W - 1)) - 1;
            return r[STATE_W-1:0];
        endfunction

        // transposed direct form ii, a-terms taken as (-a)*y
        function t_state section(int sec, t_state x);
            t_state y;
            y = sat_add(coef_mul(coef(sec, CK_B0), x), delays[2*sec]);
            delays[2*sec] = sat_add(sat_add(coef_mul(coef(sec, CK_B1), x),
                                            coef_mul(-coef(sec, CK_A1), y)),
                                    delays[2*sec+1]);
            delays[2*sec+1] = sat_add(coef_mul(coef(sec, CK_B2), x),
                                      coef_mul(-coef(sec, CK_A2), y));
            return y;
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] sample, logic last);
            t_state                  y;
            logic signed [STATE_W:0] t;
            logic signed [32:0]      q;
            t_eq_result              res;
            y = STATE_W'($signed(sample));
            y = y <<< ALIGN;
            for (int sec = 0; sec < NUM_SECT; sec++) y = section(sec, y);
            y = coef_mul(coef(0, GAIN_IDX), y);
            // back to sample format, half rounds up
            t = (STATE_W+1)'(y);
            t = t + ((STATE_W+1)'(1) <<< (ALIGN - 1));
            q = 33'(t >>> ALIGN);
            res.last = last;
            res.clipped = 1'b0;
            res.sample = q[SAMPLE_W-1:0];
            if (q > SAMPLE_MAX) begin
                res.sample = S_MAX;
                res.clipped = 1'b1;
            end else if (q < SAMPLE_MIN) begin
                res.sample = S_MIN;
                res.clipped = 1'b1;
            end
            expected_q.push_back(res);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(string what);
            $display("%0t ns: %s", $time, what);
            fail_count++;
        endtask

        task check_result(logic [SAMPLE_W-1:0] sample, logic clipped, logic last);
            t_eq_result want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result beat 0x%06h with no sample pending", sample));
                return;
            end
            want = expected_q.pop_front();
            if (sample !== want.sample)
                report_mismatch($sformatf("sample_out 0x%06h, predicted 0x%06h",
                                          sample, want.sample));
            if (clipped !== want.clipped)
                report_mismatch($sformatf("clipped %b, predicted %b", clipped, want.clipped));
            if (last !== want.last)
                report_mismatch($sformatf("last_out %b, predicted %b", last, want.last));
        endtask
    endclass

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [DATA_W-1:0]   s_axis_tdata  = '0;   // [23:0] sample_in
    logic                s_axis_tlast  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [DATA_W-1:0]   m_axis_tdata;         // [23:0] sample_out
    logic                m_axis_tuser;         // [0] clipped
    logic                m_axis_tlast;
    logic                i_cfg_wr_en   = 1'b0;
    logic [CFG_AW-1:0]   i_cfg_addr    = '0;
    logic [CFG_W-1:0]    i_cfg_wdata   = '0;

    // idle chance in percent for the sample side and the result side
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    t_eq_scoreboard      sb;
    // register image for the next write pass
    logic [CFG_W-1:0]    cfg_next [NUM_REGS];

    three_biquad_cascade_eq_core #(
        .SAMPLE_WIDTH(SAMPLE_W),
        .STATE_WIDTH (STATE_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side: values read right after the edge are the ones the block saw
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[SAMPLE_W-1:0], m_axis_tuser, m_axis_tlast);
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one sample beat; a gap of random length sometimes comes first so that
    // holes fall on every step of the item schedule
    task automatic send_sample(logic [SAMPLE_W-1:0] sample, logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(sample, last);
    endtask

    // all eight registers, one per cycle; only called with the block idle
    task automatic write_config();
        for (int i = 0; i < NUM_REGS; i++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_addr  <= CFG_AW'(i);
            i_cfg_wdata <= cfg_next[i];
            @(posedge i_clk);
            sb.write_reg(i, cfg_next[i]);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    // every owed result back, then an extra idle margin
    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    function automatic logic [COEF_W-1:0] rand_coef(int unsigned span);
        return COEF_W'($urandom_range(2 * span) - span);
    endfunction

    // bounded random coefficients: sections stay stable, gain within +-2.0
    function automatic void set_stable_config();
        int unsigned span;
        for (int f = 0; f < 2 * NUM_REGS; f++) begin
            case ((f == GAIN_IDX) ? int'(GAIN_IDX) : f % TERMS_PER_SECT)
                CK_B0, CK_B1, CK_B2: span = 3 << 27;
                CK_A1:               span = 120_000_000;
                CK_A2:               span = 1 << 27;
                default:             span = 1 << 29;
            endcase
            cfg_next[f / 2][(f % 2) * COEF_W +: COEF_W] = rand_coef(span);
        end
    endfunction

    // half the picks at moderate levels so that stable filters do not just clip
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:          return $urandom_range(1) ? S_MAX : S_MIN;
            1, 2, 3, 4: return SAMPLE_W'($urandom);
            default:    return SAMPLE_W'($urandom_range(1 << 19) - (1 << 18));
        endcase
    endfunction

    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pass-through after reset: extremes and the block-end marker
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b1);
        send_sample(SAMPLE_W'(1), 1'b0);

        // gain 0.5: odd samples land on a half and round up
        wait_results_done();
        foreach (cfg_next[i]) cfg_next[i] = CFG_RESET[i];
        cfg_next[GAIN_IDX / 2][COEF_W +: COEF_W] = 32'h0800_0000;
        write_config();
        send_sample(SAMPLE_W'(1), 1'b0);
        send_sample('1, 1'b1);
        send_sample(SAMPLE_W'(3), 1'b0);
        send_sample(SAMPLE_W'(-3), 1'b1);

        // gain 2.0: output clamps at both ends
        wait_results_done();
        cfg_next[GAIN_IDX / 2][COEF_W +: COEF_W] = 32'h2000_0000;
        write_config();
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(SAMPLE_W'(1 << 22), 1'b1);

        // largest positive coefficients everywhere: internal saturation
        wait_results_done();
        foreach (cfg_next[i]) cfg_next[i] = {2{32'h7FFF_FFFF}};
        write_config();
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(SAMPLE_W'(1), 1'b1);

        // most negative coefficients: negated a-terms reach +2^31
        wait_results_done();
        foreach (cfg_next[i]) cfg_next[i] = {2{32'h8000_0000}};
        write_config();
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b1);
        send_sample(SAMPLE_W'(1), 1'b0);

        // random part: three idle patterns, each with a fully random register set
        // between two stable ones
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_results_done();
            case (ph / 3)
                0: begin
                    send_idle_pct = 14;
                    recv_idle_pct = 46;
                end
                1: begin
                    send_idle_pct = 46;
                    recv_idle_pct = 14;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (ph % 3 == 1)
                foreach (cfg_next[i]) cfg_next[i] = {$urandom, $urandom};
            else
                set_stable_config();
            write_config();
            repeat (BEATS_PER_PHASE) send_sample(pick_sample(), $urandom_range(7) == 0);
        end

        wait_results_done();
        if (sb.fail_count == 0)
            $display("three_biquad_cascade_eq_core: match");
        else
            $display("three_biquad_cascade_eq_core: mismatch");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("three_biquad_cascade_eq_core: mismatch");
        $finish;
    end

endmodule
